/* rtl/tsen_pkg.sv */
// Shared types, constants and character codes of the text stream escape and number unit.
package tsen_pkg;

	localparam int NUMBER_DIGITS = 6;
	localparam int PREFIX_LEN = NUMBER_DIGITS + 1;
	localparam int BODY_MAX = 4;
	localparam int MAX_RESULTS = PREFIX_LEN + BODY_MAX;
	localparam int POS_W = $clog2(MAX_RESULTS);
	localparam int NUM_IDX_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
	localparam int BODY_IDX_W = $clog2(BODY_MAX);
	localparam int BODY_CNT_W = $clog2(BODY_MAX + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_MODE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SQUEEZE_BLANK = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MARK_LINE_END = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_TABS = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_NONPRINTING = 3'd4;

	localparam logic [1:0] NUM_MODE_OFF = 2'd0;
	localparam logic [1:0] NUM_MODE_ALL = 2'd1;
	localparam logic [1:0] NUM_MODE_NONBLANK = 2'd2;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_CARET_BASE = 8'h40;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_M = 8'h4D;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [3:0] DIGIT_ZERO_HI = 4'h3;

	typedef logic [NUMBER_DIGITS-1:0][3:0] bcd_t;
	typedef logic [NUMBER_DIGITS-1:0][7:0] num_text_t;

	localparam bcd_t BCD_ONE = (NUMBER_DIGITS * 4)'(1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} text_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} glyph_item_t;

	typedef enum logic [1:0] {
		PRE_NONE,
		PRE_NUMBER,
		PRE_BLANK
	} prefix_kind_t;

	typedef struct packed {
		prefix_kind_t                  prefix;
		num_text_t                     num_chars;
		logic [BODY_MAX-1:0][7:0]      body;
		logic [BODY_CNT_W-1:0]         body_cnt;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

/* rtl/tsen_front.sv */
// Front end: configuration registers, line state and classification of each text item.
module tsen_front
	import tsen_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   text_valid,
	input  text_item_t             text_item,
	input  queue_status_t          qstat,
	output logic                   push,
	output job_t                   job
);

	logic [1:0] number_mode_q;
	logic       squeeze_blank_q;
	logic       mark_line_end_q;
	logic       show_tabs_q;
	logic       show_nonprinting_q;

	logic at_start_q;
	logic blank_q;
	bcd_t digits_q;

	logic       accept;
	logic       eff_start;
	logic       eff_blank;
	bcd_t       eff_digits;
	logic       nl;
	logic       number_all;
	logic       number_nonblank;
	logic       squash;
	logic       do_number;
	logic       blank_next;
	logic [7:0] c;
	logic [7:0] b;

	function automatic bcd_t bcd_inc_sat(bcd_t v);
		bcd_t r;
		logic carry;
		logic all_nine;
		r = v;
		carry = 1'b1;
		all_nine = 1'b1;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (v[i] != 4'd9) begin
				all_nine = 1'b0;
			end
			if (carry) begin
				if (v[i] == 4'd9) begin
					r[i] = 4'd0;
				end else begin
					r[i] = v[i] + 4'd1;
					carry = 1'b0;
				end
			end
		end
		if (all_nine) begin
			r = v;
		end
		return r;
	endfunction

	function automatic num_text_t bcd_format(bcd_t v);
		num_text_t t;
		logic zero_above;
		t = '0;
		zero_above = 1'b1;
		for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
			if (zero_above && v[i] == 4'd0 && i != 0) begin
				t[NUMBER_DIGITS-1-i] = CH_SPACE;
			end else begin
				t[NUMBER_DIGITS-1-i] = {DIGIT_ZERO_HI, v[i]};
			end
			zero_above = zero_above && (v[i] == 4'd0);
		end
		return t;
	endfunction

	assign accept = text_valid && !qstat.full;
	assign c = text_item.data_byte;
	assign b = {1'b0, c[6:0]};
	assign nl = (c == CH_NL);
	assign number_all = (number_mode_q == NUM_MODE_ALL);
	assign number_nonblank = number_mode_q[1];

	assign eff_start = text_item.file_start || at_start_q;
	assign eff_blank = text_item.file_start ? 1'b0 : blank_q;
	assign eff_digits = text_item.file_start ? BCD_ONE : digits_q;

	assign squash = eff_start && squeeze_blank_q && nl && eff_blank;
	assign blank_next = (eff_start && squeeze_blank_q) ? nl : eff_blank;
	assign do_number = eff_start && !squash && (number_all || (number_nonblank && !nl));
	assign push = accept && !squash;

	always_comb begin
		job = '0;
		job.num_chars = bcd_format(eff_digits);
		if (do_number) begin
			job.prefix = PRE_NUMBER;
		end else if (nl && mark_line_end_q && eff_start && number_nonblank) begin
			job.prefix = PRE_BLANK;
		end else begin
			job.prefix = PRE_NONE;
		end
		if (nl) begin
			if (mark_line_end_q) begin
				job.body[0] = CH_DOLLAR;
				job.body[1] = CH_NL;
				job.body_cnt = BODY_CNT_W'(2);
			end else begin
				job.body[0] = CH_NL;
				job.body_cnt = BODY_CNT_W'(1);
			end
		end else if (c == CH_TAB) begin
			if (show_tabs_q) begin
				job.body[0] = CH_CARET;
				job.body[1] = CH_I;
				job.body_cnt = BODY_CNT_W'(2);
			end else begin
				job.body[0] = CH_TAB;
				job.body_cnt = BODY_CNT_W'(1);
			end
		end else if (show_nonprinting_q) begin
			case ({c[7], (b < 8'd32) || (b == CH_DEL)})
				2'b11: begin
					job.body[0] = CH_M;
					job.body[1] = CH_DASH;
					job.body[2] = CH_CARET;
					job.body[3] = (b == CH_DEL) ? CH_QUEST : (CH_CARET_BASE | b);
					job.body_cnt = BODY_CNT_W'(4);
				end
				2'b10: begin
					job.body[0] = CH_M;
					job.body[1] = CH_DASH;
					job.body[2] = b;
					job.body_cnt = BODY_CNT_W'(3);
				end
				2'b01: begin
					job.body[0] = CH_CARET;
					job.body[1] = (b == CH_DEL) ? CH_QUEST : (CH_CARET_BASE | b);
					job.body_cnt = BODY_CNT_W'(2);
				end
				default: begin
					job.body[0] = c;
					job.body_cnt = BODY_CNT_W'(1);
				end
			endcase
		end else begin
			job.body[0] = c;
			job.body_cnt = BODY_CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_mode_q <= NUM_MODE_OFF;
			squeeze_blank_q <= 1'b0;
			mark_line_end_q <= 1'b0;
			show_tabs_q <= 1'b0;
			show_nonprinting_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_NUMBER_MODE: number_mode_q <= cfg_data[1:0];
				CFG_SQUEEZE_BLANK: squeeze_blank_q <= cfg_data[0];
				CFG_MARK_LINE_END: mark_line_end_q <= cfg_data[0];
				CFG_SHOW_TABS: show_tabs_q <= cfg_data[0];
				CFG_SHOW_NONPRINTING: show_nonprinting_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			blank_q <= 1'b0;
			digits_q <= BCD_ONE;
		end else if (accept) begin
			at_start_q <= nl;
			blank_q <= blank_next;
			digits_q <= do_number ? bcd_inc_sat(eff_digits) : eff_digits;
		end
	end

endmodule

/* rtl/tsen_queue.sv */
// Short job queue between the front end and the output sequencer.
module tsen_queue
	import tsen_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  job_t          push_job,
	input  logic          pop,
	output job_t          head,
	output queue_status_t qstat
);

	job_t                   entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign head = entry_q[rd_ptr_q];
	assign qstat.full = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + QUEUE_CNT_W'(1);
				2'b01: count_q <= count_q - QUEUE_CNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule

/* rtl/tsen_back.sv */
// Output sequencer: walks the head job and sends one character per cycle while the receiver does not stall.
module tsen_back
	import tsen_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  job_t          head,
	input  queue_status_t qstat,
	output logic          pop,
	output logic          glyph_valid,
	input  logic          glyph_stall,
	output glyph_item_t   glyph_item
);

	logic [POS_W-1:0] pos_q;
	logic             valid_q;
	glyph_item_t      glyph_q;

	logic [POS_W-1:0] pre_len;
	logic [POS_W-1:0] total;
	logic [POS_W-1:0] body_pos;
	logic [7:0]       cur_byte;
	logic             cur_last;
	logic             advance;
	logic             load;

	assign pre_len = (head.prefix == PRE_NONE) ? '0 : POS_W'(PREFIX_LEN);
	assign total = pre_len + POS_W'(head.body_cnt);
	assign body_pos = pos_q - pre_len;
	assign cur_last = (pos_q == total - POS_W'(1));

	always_comb begin
		if (pos_q < pre_len) begin
			if (pos_q == POS_W'(NUMBER_DIGITS)) begin
				cur_byte = CH_TAB;
			end else if (head.prefix == PRE_NUMBER) begin
				cur_byte = head.num_chars[pos_q[NUM_IDX_W-1:0]];
			end else begin
				cur_byte = CH_SPACE;
			end
		end else begin
			cur_byte = head.body[body_pos[BODY_IDX_W-1:0]];
		end
	end

	assign advance = !valid_q || !glyph_stall;
	assign load = advance && !qstat.empty;
	assign pop = load && cur_last;

	assign glyph_valid = valid_q;
	assign glyph_item = glyph_q;

	always_ff @(posedge clk) begin
		if (load) begin
			glyph_q.out_byte <= cur_byte;
			glyph_q.last_of_run <= cur_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			pos_q <= cur_last ? '0 : pos_q + POS_W'(1);
		end else if (advance) begin
			valid_q <= 1'b0;
		end
	end

endmodule

/* rtl/text_stream_escape_and_number_unit.sv */
// Top level of the text stream escape and number unit.
// Text items (a byte and a file start flag) enter on text_valid/text_stall; each one
// becomes zero to eleven output characters on glyph_valid/glyph_stall, the last one of
// each item flagged by last_of_run. A squeezed blank line gives no character at all.
// Options are written through cfg_valid/cfg_ready with cfg_index selecting the register
// (number mode, squeeze, line end mark, tab display, nonprinting display); cfg_ready is
// always high and writes are meant for idle periods.
// The front end classifies an item in the cycle it is accepted and places a job in a
// four-entry queue; the sequencer sends one character per cycle from the head job
// while the receiver does not stall. An item's first character passes through the queue
// entry and then the output register. Without receiver stalls the output carries one
// character per cycle, so items giving one character each flow at one item per cycle;
// an item with a line number first sends its seven prefix characters. text_stall rises
// only when the queue is full. When the receiver stalls, the output register holds its
// character and the queue absorbs up to four more items before text_stall is raised.
// Reset clears the options, sets the line state to a line start with counter one, and
// empties the queue and output register.
module text_stream_escape_and_number_unit
	import tsen_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   text_valid,
	output logic                   text_stall,
	input  text_item_t             text_item,
	output logic                   glyph_valid,
	input  logic                   glyph_stall,
	output glyph_item_t            glyph_item
);

	queue_status_t qstat;
	logic          push;
	logic          pop;
	job_t          push_job;
	job_t          head;

	assign cfg_ready = 1'b1;
	assign text_stall = qstat.full;

	tsen_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.text_valid (text_valid),
		.text_item  (text_item),
		.qstat      (qstat),
		.push       (push),
		.job        (push_job)
	);

	tsen_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	tsen_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.qstat       (qstat),
		.pop         (pop),
		.glyph_valid (glyph_valid),
		.glyph_stall (glyph_stall),
		.glyph_item  (glyph_item)
	);

endmodule

/* test/text_stream_escape_and_number_unit_tb.sv */
// Self-checking testbench for the text stream escape and number unit.
`timescale 1ns / 100ps

module text_stream_escape_and_number_unit_tb;
	import tsen_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
	localparam logic [1:0] NUM_MODE_BOTH = 2'd3;
	localparam logic [7:0] CH_ZERO = {DIGIT_ZERO_HI, 4'h0};
	localparam logic [19:0] LINE_LIMIT = 20'(10 ** NUMBER_DIGITS - 1);
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic text_valid = 1'b0;
	logic text_stall;
	text_item_t text_item = '0;
	logic glyph_valid;
	logic glyph_stall = 1'b0;
	glyph_item_t glyph_item;

	text_item_t text_backlog[$];
	glyph_item_t expected_glyphs[$];

	logic [1:0] opt_number_mode = NUM_MODE_OFF;
	logic opt_squeeze = 1'b0;
	logic opt_mark_end = 1'b0;
	logic opt_show_tabs = 1'b0;
	logic opt_nonprinting = 1'b0;

	logic at_line_start = 1'b1;
	logic blank_seen = 1'b0;
	logic [19:0] line_count = 20'd1;

	logic text_taken = 1'b0;
	logic glyph_taken = 1'b0;
	bit sender_idles = 1'b0;
	bit receiver_idles = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	int hold_requests = 0;
	int hold_served = 0;

	int error_count = 0;
	int items_accepted = 0;
	int glyphs_checked = 0;
	int squeezed_lines = 0;
	int settings_used = 0;

	text_stream_escape_and_number_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_item(text_item),
		.glyph_valid(glyph_valid),
		.glyph_stall(glyph_stall),
		.glyph_item(glyph_item)
	);

	always #2 clk = ~clk;

	// Rewrites one text byte into the characters it should produce.
	task automatic escape_byte(input text_item_t it);
		logic [7:0] c;
		logic [7:0] b;
		logic nl;
		logic was_start;
		logic nonblank_mode;
		logic [19:0] v;
		logic [7:0] digits[NUMBER_DIGITS];
		logic [7:0] chars[$];
		glyph_item_t g;
		int i;
		c = it.data_byte;
		nl = (c == CH_NL);
		nonblank_mode = (opt_number_mode >= NUM_MODE_NONBLANK);
		if (it.file_start) begin
			at_line_start = 1'b1;
			blank_seen = 1'b0;
			line_count = 20'd1;
		end
		was_start = at_line_start;
		if (was_start) begin
			if (opt_squeeze) begin
				if (nl) begin
					if (blank_seen) begin
						squeezed_lines++;
						return;
					end
					blank_seen = 1'b1;
				end else begin
					blank_seen = 1'b0;
				end
			end
			if (opt_number_mode == NUM_MODE_ALL || (nonblank_mode && !nl)) begin
				v = line_count;
				for (i = NUMBER_DIGITS - 1; i >= 0; i--) begin
					digits[i] = (v != 0 || i == NUMBER_DIGITS - 1) ? CH_ZERO + 8'(v % 10)
						: CH_SPACE;
					v = v / 10;
				end
				for (i = 0; i < NUMBER_DIGITS; i++)
					chars.push_back(digits[i]);
				chars.push_back(CH_TAB);
				if (line_count < LINE_LIMIT)
					line_count++;
			end
		end
		if (nl) begin
			if (opt_mark_end) begin
				if (was_start && nonblank_mode) begin
					for (i = 0; i < NUMBER_DIGITS; i++)
						chars.push_back(CH_SPACE);
					chars.push_back(CH_TAB);
				end
				chars.push_back(CH_DOLLAR);
			end
			chars.push_back(c);
		end else if (c == CH_TAB) begin
			if (opt_show_tabs) begin
				chars.push_back(CH_CARET);
				chars.push_back(CH_I);
			end else begin
				chars.push_back(c);
			end
		end else if (opt_nonprinting) begin
			b = c;
			if (b[7]) begin
				chars.push_back(CH_M);
				chars.push_back(CH_DASH);
				b[7] = 1'b0;
			end
			if (b < 8'd32 || b == CH_DEL) begin
				chars.push_back(CH_CARET);
				chars.push_back(b == CH_DEL ? CH_QUEST : b + CH_CARET_BASE);
			end else begin
				chars.push_back(b);
			end
		end else begin
			chars.push_back(c);
		end
		at_line_start = nl;
		for (i = 0; i < chars.size(); i++) begin
			g.out_byte = chars[i];
			g.last_of_run = (i == chars.size() - 1);
			expected_glyphs.push_back(g);
		end
	endtask

	always @(posedge clk) begin : watch_ports
		glyph_item_t want;
		text_taken <= arst_n && text_valid && !text_stall;
		glyph_taken <= arst_n && glyph_valid && !glyph_stall;
		if (arst_n && glyph_valid && !glyph_stall) begin
			glyphs_checked++;
			if (expected_glyphs.size() == 0) begin
				$error("Unexpected output character %h", glyph_item.out_byte);
				error_count++;
			end else begin
				want = expected_glyphs.pop_front();
				if (glyph_item.out_byte !== want.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte, glyph_item.out_byte);
					error_count++;
				end
				if (glyph_item.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %b, got %b", want.last_of_run,
						glyph_item.last_of_run);
					error_count++;
				end
			end
		end
		if (arst_n && text_valid && !text_stall) begin
			items_accepted++;
			escape_byte(text_item);
		end
	end

	always @(negedge clk) begin
		if (arst_n && !(text_valid && !text_taken)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				text_valid <= 1'b0;
			end else if (text_backlog.size() > 0) begin
				text_item <= text_backlog.pop_front();
				text_valid <= 1'b1;
				send_gap <= (sender_idles && $urandom_range(0, 1)) ? $urandom_range(0, 19) : 0;
			end else begin
				text_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = LONG_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			glyph_stall <= 1'b1;
		end else begin
			if (glyph_taken)
				stall_left = (receiver_idles && $urandom_range(0, 1)) ? $urandom_range(0, 19) : 0;
			if (stall_left > 0) begin
				stall_left = stall_left - 1;
				glyph_stall <= 1'b1;
			end else begin
				glyph_stall <= 1'b0;
			end
		end
	end

	task automatic wait_idle();
		do
			@(posedge clk);
		while (text_backlog.size() != 0 || text_valid || expected_glyphs.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_option(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_NUMBER_MODE: opt_number_mode = val[1:0];
			CFG_SQUEEZE_BLANK: opt_squeeze = val[0];
			CFG_MARK_LINE_END: opt_mark_end = val[0];
			CFG_SHOW_TABS: opt_show_tabs = val[0];
			CFG_SHOW_NONPRINTING: opt_nonprinting = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_options(input logic [1:0] mode, input bit sq, input bit mark,
		input bit tabs, input bit np);
		wait_idle();
		write_option(CFG_NUMBER_MODE, {6'($urandom), mode});
		write_option(CFG_SQUEEZE_BLANK, {7'($urandom), sq});
		write_option(CFG_MARK_LINE_END, {7'($urandom), mark});
		write_option(CFG_SHOW_TABS, {7'($urandom), tabs});
		write_option(CFG_SHOW_NONPRINTING, {7'($urandom), np});
		settings_used++;
	endtask

	task automatic queue_byte(input logic [7:0] data, input logic fs);
		text_item_t it;
		it.data_byte = data;
		it.file_start = fs;
		text_backlog.push_back(it);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			6: return CH_TAB;
			7: return 8'($urandom_range(0, 31));
			8: return 8'($urandom_range(128, 255));
			9: return $urandom_range(0, 1) ? CH_DEL : 8'hFF;
			default: return 8'($urandom_range(32, 126));
		endcase
	endfunction

	// Mostly whole lines with random content, plus runs of blank lines and raw noise.
	task automatic queue_random_text(input int count);
		int queued;
		int len;
		int j;
		queued = 0;
		while (queued < count) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_byte(8'($urandom), $urandom_range(0, 7) == 0);
				queued++;
			end else if ($urandom_range(0, 4) == 0) begin
				len = $urandom_range(1, 4);
				for (j = 0; j < len; j++)
					queue_byte(CH_NL, j == 0 && $urandom_range(0, 9) == 0);
				queued += len;
			end else begin
				len = $urandom_range(1, 7);
				for (j = 0; j < len; j++)
					queue_byte(pick_byte(), (j == 0 && $urandom_range(0, 19) == 0)
						|| $urandom_range(0, 49) == 0);
				queue_byte(CH_NL, 1'b0);
				queued += len + 1;
			end
		end
	endtask

	task automatic run_random_phase(input logic [1:0] mode, input bit sq, input bit mark,
		input bit tabs, input bit np, input bit tx_idle, input bit rx_idle, input bit hold);
		set_options(mode, sq, mark, tabs, np);
		sender_idles = tx_idle;
		receiver_idles = rx_idle;
		queue_random_text(75);
		if (hold)
			hold_requests++;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_option(CFG_UNUSED_INDEX, 8'($urandom));
		set_options(NUM_MODE_ALL, 1'b1, 1'b1, 1'b1, 1'b1);
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		queue_byte("A", 1'b1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h1F, 1'b0);
		queue_byte(CH_DEL, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h89, 1'b0);
		queue_byte(CH_TAB, 1'b0);
		queue_byte(CH_NL, 1'b0);
		queue_byte(CH_NL, 1'b0);
		queue_byte(CH_NL, 1'b0);
		queue_byte(CH_NL, 1'b0);
		queue_byte(CH_SPACE, 1'b0);
		queue_byte(8'h7E, 1'b0);
		queue_byte(CH_NL, 1'b0);

		set_options(NUM_MODE_NONBLANK, 1'b0, 1'b1, 1'b0, 1'b1);
		queue_byte(CH_NL, 1'b0);
		queue_byte(CH_TAB, 1'b0);
		queue_byte(8'h9B, 1'b0);
		queue_byte(CH_NL, 1'b0);
		queue_byte(CH_NL, 1'b0);
		queue_byte(CH_NL, 1'b1);

		run_random_phase(NUM_MODE_OFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
		run_random_phase(NUM_MODE_ALL, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
		run_random_phase(NUM_MODE_NONBLANK, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
		run_random_phase(NUM_MODE_BOTH, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
		run_random_phase(NUM_MODE_ALL, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
		run_random_phase(NUM_MODE_NONBLANK, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
		wait_idle();

		$display("Run covered %0d text items and %0d output characters",
			items_accepted, glyphs_checked);
		$display("under %0d option settings, with %0d squeezed blank lines and a long hold-off.",
			settings_used, squeezed_lines);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout: %0d output characters still expected", expected_glyphs.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
